@@ hdl/bdi_pkg.sv @@
// Shared types, codes and reset constants for the block direction interlock.
`timescale 1ns / 1ps
`default_nettype none

package bdi_pkg;

    localparam int HOLD_W      = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd13;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_RECEIVING_SIDE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AUX_HOLD_TICKS = 2'd1;

    // Item kinds.
    localparam logic KIND_CLICK = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Button codes.
    localparam logic [2:0] BTN_ROUTE     = 3'd0;
    localparam logic [2:0] BTN_TOTAL_AUX = 3'd1;
    localparam logic [2:0] BTN_SEND_AUX  = 3'd2;
    localparam logic [2:0] BTN_RECV_AUX  = 3'd3;
    localparam logic [2:0] BTN_CHANGE    = 3'd4;

    // Neighbour arrow codes.
    localparam logic [1:0] PEER_ARROW_RECV      = 2'd0;
    localparam logic [1:0] PEER_ARROW_SEND      = 2'd1;
    localparam logic [1:0] PEER_ARROW_SEND_ALT  = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [2:0] button_index;
        logic [1:0] peer_arrow;
        logic       peer_signal_normal;
        logic       peer_section_free;
        logic       peer_change_pressed;
        logic       peer_send_aux;
        logic       peer_receive_aux;
    } item_t;

    typedef struct packed {
        logic              route_btn;
        logic              total_aux_btn;
        logic              send_aux_btn;
        logic              recv_aux_btn;
        logic              change_btn;
        logic [HOLD_W-1:0] send_cnt;
        logic [HOLD_W-1:0] recv_cnt;
        logic              arrow;
        logic              enable;
        logic              signal;
        logic              change;
    } state_t;

    typedef struct packed {
        logic arrow_send;
        logic send_enabled;
        logic route_pressed;
        logic signal_normal;
        logic total_aux_on;
        logic send_aux_on;
        logic receive_aux_on;
        logic change_on;
    } result_t;

    // State after reset or after a write of the side register.
    function automatic state_t init_state(input logic rx);
        state_t s;
        s.route_btn     = 1'b0;
        s.total_aux_btn = 1'b0;
        s.send_aux_btn  = 1'b0;
        s.recv_aux_btn  = 1'b0;
        s.change_btn    = 1'b0;
        s.send_cnt      = '0;
        s.recv_cnt      = '0;
        s.arrow         = ~rx;
        s.enable        = ~rx;
        s.signal        = 1'b1;
        s.change        = 1'b0;
        return s;
    endfunction

endpackage

`default_nettype wire

@@ hdl/bdi_step.sv @@
// Next-state logic for one click or tick transaction of the direction interlock.
`timescale 1ns / 1ps
`default_nettype none

module bdi_step
(
    input  wire logic                       receiving_side,
    input  wire logic [bdi_pkg::HOLD_W-1:0] aux_hold_ticks,
    input  wire bdi_pkg::state_t            state_cur,
    input  wire bdi_pkg::item_t             item,
    output bdi_pkg::state_t                 state_next,
    output bdi_pkg::result_t                result
);

    always_comb
    begin
        bdi_pkg::state_t s;
        logic peer_send;
        logic send_aux_now;
        logic recv_aux_now;

        s = state_cur;
        peer_send = (item.peer_arrow == bdi_pkg::PEER_ARROW_SEND) ||
                    (item.peer_arrow == bdi_pkg::PEER_ARROW_SEND_ALT);
        send_aux_now = 1'b0;
        recv_aux_now = 1'b0;

        if (item.kind == bdi_pkg::KIND_CLICK)
        begin
            case (item.button_index)
                bdi_pkg::BTN_ROUTE:
                begin
                    s.route_btn = ~s.route_btn;
                end
                bdi_pkg::BTN_TOTAL_AUX:
                begin
                    s.total_aux_btn = ~s.total_aux_btn;
                end
                bdi_pkg::BTN_SEND_AUX:
                begin
                    if (s.total_aux_btn)
                    begin
                        s.send_aux_btn = 1'b1;
                        s.send_cnt     = aux_hold_ticks;
                    end
                end
                bdi_pkg::BTN_RECV_AUX:
                begin
                    if (s.total_aux_btn)
                    begin
                        s.recv_aux_btn = 1'b1;
                        s.recv_cnt     = aux_hold_ticks;
                    end
                end
                bdi_pkg::BTN_CHANGE:
                begin
                    if (receiving_side)
                    begin
                        if (s.change_btn)
                            s.change_btn = 1'b0;
                        else if (item.peer_signal_normal)
                            s.change_btn = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            // Auxiliary buttons drop on the first tick after total aux is released.
            if (!s.total_aux_btn)
            begin
                s.send_aux_btn = 1'b0;
                s.recv_aux_btn = 1'b0;
            end
            if (s.send_aux_btn)
            begin
                s.send_cnt = s.send_cnt - 1'b1;
                if (s.send_cnt == '0)
                    s.send_aux_btn = 1'b0;
            end
            if (s.recv_aux_btn)
            begin
                s.recv_cnt = s.recv_cnt - 1'b1;
                if (s.recv_cnt == '0)
                    s.recv_aux_btn = 1'b0;
            end
            send_aux_now = s.send_aux_btn;
            recv_aux_now = s.recv_aux_btn;
            s.signal = ~s.route_btn;

            if (receiving_side)
            begin
                s.change = s.change_btn;
                if (!s.signal && s.enable && s.change)
                begin
                    s.arrow = 1'b1;
                end
                else if (!s.signal && !s.enable && s.change && item.peer_signal_normal)
                begin
                    s.arrow  = 1'b1;
                    s.enable = 1'b1;
                end
                else if (!s.enable && peer_send)
                begin
                    s.arrow = 1'b0;
                end
                if (peer_send && s.arrow && s.signal)
                begin
                    s.enable = 1'b0;
                    s.change = 1'b0;
                end
                if (item.peer_signal_normal && !item.peer_section_free &&
                    recv_aux_now && item.peer_send_aux)
                begin
                    s.enable = 1'b0;
                    s.arrow  = 1'b0;
                    s.change = 1'b0;
                end
            end
            else
            begin
                if (!s.signal && (s.arrow || (item.peer_signal_normal &&
                    !item.peer_change_pressed && item.peer_section_free)))
                    s.arrow = 1'b1;
                else if (peer_send)
                    s.arrow = 1'b0;
                s.enable = s.arrow;
            end

            if (send_aux_now && item.peer_receive_aux)
            begin
                s.arrow  = 1'b1;
                s.enable = 1'b1;
            end
        end

        state_next = s;
        result.arrow_send     = s.arrow;
        result.send_enabled   = s.enable;
        result.route_pressed  = s.route_btn;
        result.signal_normal  = s.signal;
        result.total_aux_on   = s.total_aux_btn;
        result.send_aux_on    = s.send_aux_btn;
        result.receive_aux_on = s.recv_aux_btn;
        result.change_on      = s.change;
    end

endmodule

`default_nettype wire

@@ hdl/block_direction_interlock.sv @@
// Top level of the block direction interlock: registers, handshakes and configuration.
// A transaction is captured in the input register, and its result in the result register.
// Throughput: one transaction per cycle unless out_ready holds the result register;
// the bdi_step state update sets the rate: each reads the state the last one left.
// Reset: rst_n clears all pipeline valids and sets sending-side rules, a hold time
// of 13 ticks, arrow and send enable on, signal normal on, all buttons off.
`timescale 1ns / 1ps
`default_nettype none

module block_direction_interlock
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    // Configuration write port.
    input  wire logic                            cfg_we,
    input  wire logic [bdi_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bdi_pkg::CFG_DATA_W-1:0]  cfg_data,

    // Input channel.
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            kind,
    input  wire logic [2:0]                      button_index,
    input  wire logic [1:0]                      peer_arrow,
    input  wire logic                            peer_signal_normal,
    input  wire logic                            peer_section_free,
    input  wire logic                            peer_change_pressed,
    input  wire logic                            peer_send_aux,
    input  wire logic                            peer_receive_aux,

    // Output channel.
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 arrow_send,
    output logic                                 send_enabled,
    output logic                                 route_pressed,
    output logic                                 signal_normal,
    output logic                                 total_aux_on,
    output logic                                 send_aux_on,
    output logic                                 receive_aux_on,
    output logic                                 change_on
);

    // Configuration registers.
    logic                       side_reg;
    logic [bdi_pkg::HOLD_W-1:0] hold_reg;

    // Interlock state, updated once per transaction that leaves the input register.
    bdi_pkg::state_t state_reg;
    bdi_pkg::state_t state_next;

    // Input register: holds one accepted transaction until the step logic consumes it.
    logic            item_valid_reg;
    bdi_pkg::item_t  item_reg;

    // Result register: decouples the output handshake from the state update.
    logic             out_valid_reg;
    bdi_pkg::result_t result_reg;
    bdi_pkg::result_t result_next;

    logic in_fire;
    logic advance;

    // The step stage advances whenever it has a transaction and the result
    // register is empty or being emptied this cycle.
    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    bdi_step u_step
    (
        .receiving_side (side_reg),
        .aux_hold_ticks (hold_reg),
        .state_cur      (state_reg),
        .item           (item_reg),
        .state_next     (state_next),
        .result         (result_next)
    );

    // Configuration registers and interlock state. A write of the side register
    // re-initializes the state; the user must write only while idle, not enforced here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg  <= 1'b0;
            hold_reg  <= bdi_pkg::HOLD_RESET;
            state_reg <= bdi_pkg::init_state(1'b0);
        end
        else if (cfg_we)
        begin
            if (cfg_index == bdi_pkg::REG_RECEIVING_SIDE)
            begin
                side_reg  <= cfg_data[0];
                state_reg <= bdi_pkg::init_state(cfg_data[0]);
            end
            else if (cfg_index == bdi_pkg::REG_AUX_HOLD_TICKS)
            begin
                hold_reg <= cfg_data;
            end
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.kind                <= kind;
            item_reg.button_index        <= button_index;
            item_reg.peer_arrow          <= peer_arrow;
            item_reg.peer_signal_normal  <= peer_signal_normal;
            item_reg.peer_section_free   <= peer_section_free;
            item_reg.peer_change_pressed <= peer_change_pressed;
            item_reg.peer_send_aux       <= peer_send_aux;
            item_reg.peer_receive_aux    <= peer_receive_aux;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid      = out_valid_reg;
    assign arrow_send     = result_reg.arrow_send;
    assign send_enabled   = result_reg.send_enabled;
    assign route_pressed  = result_reg.route_pressed;
    assign signal_normal  = result_reg.signal_normal;
    assign total_aux_on   = result_reg.total_aux_on;
    assign send_aux_on    = result_reg.send_aux_on;
    assign receive_aux_on = result_reg.receive_aux_on;
    assign change_on      = result_reg.change_on;

    // The change-permit button and its tick copy never come up on the sending side.
    a_no_change_btn_tx: assert property (@(posedge clk) disable iff (!rst_n)
        !side_reg |-> !state_reg.change_btn)
        else $error("change button set on sending side");

    a_no_change_tx: assert property (@(posedge clk) disable iff (!rst_n)
        !side_reg |-> !state_reg.change)
        else $error("change permit set on sending side");

    // Every transaction that leaves the input register produces a result.
    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost after step");

    // A transaction stalled in the input register is kept.
    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !advance) |=> item_valid_reg)
        else $error("stalled transaction dropped");

endmodule

`default_nettype wire
